// ===== src/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_FOREGROUND = 1'b0;
  localparam logic REG_BACKGROUND = 1'b1;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // Spaces that a tab writes after the first one.
  localparam logic [1:0] TAB_EXTRA = 2'd3;

  localparam logic [3:0] FOREGROUND_RESET = 4'd15;
  localparam logic [3:0] BACKGROUND_RESET = 4'd0;

  typedef struct packed {
    logic capture;
    logic ptr_clr;
    logic copy_step;
    logic fill_step;
    logic fill_zero;
    logic cell_write;
    logic write_space;
    logic cell_read;
    logic col_zero;
    logic col_inc;
    logic row_inc;
    logic home;
    logic result;
    logic result_read;
  } tcw_cmd_t;

  typedef struct packed {
    logic col_full;
    logic last_row;
    logic copy_last;
    logic fill_last;
    logic read_ok;
  } tcw_status_t;

endpackage

`default_nettype wire

// ===== src/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/tcw_ctrl.sv =====
// Command sequencer of the text console writer.
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_code,
  input  tcw_status_t sts,
  output tcw_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_NEWLINE, S_PLAIN, S_WRITE,
    S_COPY, S_DRAIN, S_FILL, S_READ, S_DONE
  } state_t;

  state_t     state, state_next;
  logic [1:0] tab_left, tab_left_next;
  logic       space_sel, space_sel_next;
  logic       fill_to_write, fill_to_write_next;
  logic       read_hit, read_hit_next;

  always_comb begin
    state_next         = state;
    tab_left_next      = tab_left;
    space_sel_next     = space_sel;
    fill_to_write_next = fill_to_write;
    read_hit_next      = read_hit;
    cmd                = '0;
    cmd.write_space    = space_sel;
    unique case (state)
      S_INIT: begin
        cmd.fill_step = 1'b1;
        cmd.fill_zero = 1'b1;
        if (sts.fill_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture   = 1'b1;
          read_hit_next = 1'b0;
          unique case (opcode)
            OP_PUT: begin
              if (char_code == CH_NEWLINE) begin
                state_next = S_NEWLINE;
              end else if (char_code == CH_RETURN) begin
                cmd.col_zero = 1'b1;
                state_next   = S_DONE;
              end else if (char_code == CH_TAB) begin
                tab_left_next  = TAB_EXTRA;
                space_sel_next = 1'b1;
                state_next     = S_PLAIN;
              end else begin
                tab_left_next  = '0;
                space_sel_next = 1'b0;
                state_next     = S_PLAIN;
              end
            end
            OP_CLEAR: begin
              cmd.ptr_clr        = 1'b1;
              cmd.home           = 1'b1;
              fill_to_write_next = 1'b0;
              state_next         = S_FILL;
            end
            OP_READ: begin
              state_next = S_READ;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_NEWLINE: begin
        cmd.col_zero = 1'b1;
        if (sts.last_row) begin
          cmd.ptr_clr        = 1'b1;
          fill_to_write_next = 1'b0;
          state_next         = S_COPY;
        end else begin
          cmd.row_inc = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_PLAIN: begin
        if (!sts.col_full) begin
          cmd.cell_write = 1'b1;
          cmd.col_inc    = 1'b1;
          if (tab_left != '0) begin
            tab_left_next = tab_left - 2'd1;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          cmd.col_zero = 1'b1;
          if (sts.last_row) begin
            cmd.ptr_clr        = 1'b1;
            fill_to_write_next = 1'b1;
            state_next         = S_COPY;
          end else begin
            cmd.row_inc = 1'b1;
            state_next  = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        cmd.cell_write = 1'b1;
        cmd.col_inc    = 1'b1;
        if (tab_left != '0) begin
          tab_left_next = tab_left - 2'd1;
          state_next    = S_PLAIN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_next = fill_to_write ? S_WRITE : S_DONE;
        end
      end
      S_READ: begin
        if (sts.read_ok) begin
          cmd.cell_read = 1'b1;
          read_hit_next = 1'b1;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.result      = 1'b1;
        cmd.result_read = read_hit;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      busy          <= 1'b1;
      tab_left      <= '0;
      space_sel     <= 1'b0;
      fill_to_write <= 1'b0;
      read_hit      <= 1'b0;
    end else begin
      state         <= state_next;
      busy          <= (state_next != S_IDLE);
      tab_left      <= tab_left_next;
      space_sel     <= space_sel_next;
      fill_to_write <= fill_to_write_next;
      read_hit      <= read_hit_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/tcw_datapath.sv =====
// Cursor, colors, screen store and result registers of the text console writer.
`default_nettype none

module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  tcw_cmd_t    cmd,
  output tcw_status_t sts,
  input  logic [7:0]  char_code,
  input  logic [4:0]  cell_row,
  input  logic [6:0]  cell_col,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [7:0]  read_char,
  output logic [7:0]  read_color,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col
);

  localparam int TOTAL = ROWS * COLUMNS;
  localparam int LAST  = (ROWS - 1) * COLUMNS;
  localparam int AW    = $clog2(TOTAL);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [3:0]    fg, bg;
  logic [7:0]    lat_char;
  logic [4:0]    lat_row;
  logic [6:0]    lat_col;
  logic [AW-1:0] ptr;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;

  logic [AW-1:0] cell_addr, rd_addr;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic [15:0]   blank_cell, char_cell;

  assign cell_addr  = AW'(cur_row) * COLS_A + AW'(cur_col);
  assign rd_addr    = AW'(lat_row) * COLS_A + AW'(lat_col);
  assign blank_cell = {bg, fg, CH_SPACE};
  assign char_cell  = {bg, fg, cmd.write_space ? CH_SPACE : lat_char};

  assign sts.col_full  = (cur_col == CW'(COLUMNS));
  assign sts.last_row  = (cur_row == RW'(ROWS - 1));
  assign sts.copy_last = (ptr == AW'(LAST - 1));
  assign sts.fill_last = (ptr == AW'(TOTAL - 1));
  assign sts.read_ok   = (32'(lat_row) < ROWS) && (32'(lat_col) < COLUMNS);

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = cell_addr;
    ram_wdata = char_cell;
    priority if (wr_pend) begin
      ram_waddr = wr_addr;
      ram_wdata = ram_rdata;
    end else if (cmd.fill_step) begin
      ram_waddr = ptr;
      ram_wdata = cmd.fill_zero ? 16'h0000 : blank_cell;
    end else if (cmd.cell_write) begin
      ram_waddr = cell_addr;
      ram_wdata = char_cell;
    end else begin
      ram_we = 1'b0;
    end
  end

  assign ram_re    = cmd.copy_step | cmd.cell_read;
  assign ram_raddr = cmd.copy_step ? (ptr + COLS_A) : rd_addr;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(TOTAL)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lat_char <= char_code;
      lat_row  <= cell_row;
      lat_col  <= cell_col;
    end
    wr_addr <= ptr;
    if (cmd.result) begin
      read_char  <= cmd.result_read ? ram_rdata[7:0] : 8'h00;
      read_color <= cmd.result_read ? ram_rdata[15:8] : 8'h00;
      cursor_row <= 5'(cur_row);
      cursor_col <= 7'(cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      fg      <= FOREGROUND_RESET;
      bg      <= BACKGROUND_RESET;
      ptr     <= '0;
      wr_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FOREGROUND) begin
          fg <= cfg_data;
        end else begin
          bg <= cfg_data;
        end
      end
      if (cmd.home) begin
        cur_row <= '0;
        cur_col <= '0;
      end else begin
        if (cmd.row_inc) begin
          cur_row <= cur_row + RW'(1);
        end
        if (cmd.col_zero) begin
          cur_col <= '0;
        end else if (cmd.col_inc) begin
          cur_col <= cur_col + CW'(1);
        end
      end
      if (cmd.ptr_clr) begin
        ptr <= '0;
      end else if (cmd.copy_step || cmd.fill_step) begin
        ptr <= ptr + AW'(1);
      end
      wr_pend <= cmd.copy_step;
      done    <= cmd.result;
    end
  end

endmodule

`default_nettype wire

// ===== src/text_console_writer_core.sv =====
// Top level of the text console writer: sequencer plus datapath.
//
// A command is taken at a rising edge where start is high and busy is low.
// opcode selects put character (char_code; newline, return and tab are
// interpreted), clear screen, or read of the cell at cell_row, cell_col.
// Each command yields one result beat: done is high for one cycle with
// read_char, read_color and the cursor position after the command. The
// result cannot be held off; it must be taken in that cycle.
// A new command is taken only once the last one is through: busy falls in the
// same cycle that done rises. A tab writes TAB_EXTRA more spaces after the
// first, and a character at a full row first wraps to the next line.
// A scroll walks the screen store one cell per cycle through its single
// write port: it copies the lower rows up one row, drains the last copy write
// and fills the last row with blanks. A clear fills all ROWS*COLUMNS cells.
// After reset the store is cleared to zero with busy high; color writes on
// the cfg port are taken at any time.
`default_nettype none

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [7:0] char_code,
  input  logic [4:0] cell_row,
  input  logic [6:0] cell_col,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  output logic       done,
  output logic [7:0] read_char,
  output logic [7:0] read_color,
  output logic [4:0] cursor_row,
  output logic [6:0] cursor_col
);

  tcw_cmd_t    cmd;
  tcw_status_t sts;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .opcode   (opcode),
    .char_code(char_code),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  tcw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .char_code (char_code),
    .cell_row  (cell_row),
    .cell_col  (cell_col),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .read_char (read_char),
    .read_color(read_color),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col)
  );

endmodule

`default_nettype wire

// ===== src/tcw_checker.sv =====
// Port-level checks of the text console writer and their binding.
`default_nettype none

module tcw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("A result beat lasted more than one cycle.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("The block was not busy right after taking a command.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("A result beat appeared while the block was busy.");

  a_reset_busy: assert property (@(posedge clk) rst |=> (busy && !done))
    else $error("The block was not busy clearing the screen after reset.");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

`default_nettype wire

// ===== tb/tb_text_console_writer_core.sv =====
// Self-checking testbench for text_console_writer_core with its own console model.
module tb_text_console_writer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1080;
  localparam int QUIET_TAIL = 150;
  localparam int PHASES = 5;
  localparam int SETTLE_CYCLES = 20;
  localparam longint LIMIT_CYCLES = 10_000_000;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic TYPED = 1'b1;
  localparam logic PREDICT = 1'b0;

  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] attr;
    logic [4:0] row;
    logic [6:0] col;
  } console_beat_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [7:0]    glyph;
    logic [4:0]    row;
    logic [6:0]    col;
    logic          typed;
    console_beat_t reply;
  } directed_row_t;

  localparam console_beat_t NO_REPLY = '0;
  localparam int DIRECTED_ROWS = 20;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    {OP_READ,  8'h00,      5'd0,  7'd0,   TYPED,   8'h00, 8'h00, 5'd0, 7'd0},
    {OP_READ,  8'h00,      5'd24, 7'd79,  TYPED,   8'h00, 8'h00, 5'd0, 7'd0},
    {OP_READ,  8'hFF,      5'd31, 7'd127, TYPED,   8'h00, 8'h00, 5'd0, 7'd0},
    {OP_SPARE, 8'hFF,      5'd31, 7'd127, TYPED,   8'h00, 8'h00, 5'd0, 7'd0},
    {OP_PUT,   8'h41,      5'd0,  7'd0,   PREDICT, NO_REPLY},
    {OP_PUT,   8'hFF,      5'd0,  7'd0,   PREDICT, NO_REPLY},
    {OP_PUT,   8'h00,      5'd0,  7'd0,   PREDICT, NO_REPLY},
    {OP_PUT,   CH_TAB,     5'd0,  7'd0,   PREDICT, NO_REPLY},
    {OP_READ,  8'h00,      5'd0,  7'd3,   PREDICT, NO_REPLY},
    {OP_PUT,   CH_RETURN,  5'd0,  7'd0,   PREDICT, NO_REPLY},
    {OP_PUT,   CH_NEWLINE, 5'd0,  7'd0,   PREDICT, NO_REPLY},
    {OP_PUT,   8'h7F,      5'd0,  7'd0,   PREDICT, NO_REPLY},
    {OP_READ,  8'h00,      5'd1,  7'd0,   PREDICT, NO_REPLY},
    {OP_CLEAR, 8'h00,      5'd0,  7'd0,   TYPED,   8'h00, 8'h00, 5'd0, 7'd0},
    {OP_READ,  8'h00,      5'd24, 7'd79,  TYPED,
     CH_SPACE, BACKGROUND_RESET, FOREGROUND_RESET, 5'd0, 7'd0},
    {OP_READ,  8'h00,      5'd25, 7'd0,   TYPED,   8'h00, 8'h00, 5'd0, 7'd0},
    {OP_READ,  8'h00,      5'd0,  7'd80,  TYPED,   8'h00, 8'h00, 5'd0, 7'd0},
    {OP_PUT,   8'h80,      5'd31, 7'd127, PREDICT, NO_REPLY},
    {OP_READ,  8'h00,      5'd0,  7'd0,   PREDICT, NO_REPLY},
    {OP_SPARE, 8'h00,      5'd0,  7'd0,   PREDICT, NO_REPLY}
  };

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic [4:0] cell_row;
  logic [6:0] cell_col;
  logic cfg_we;
  logic cfg_index;
  logic [3:0] cfg_data;
  logic done;
  logic [7:0] read_char;
  logic [7:0] read_color;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;

  logic [15:0] screen [SCREEN_ROWS * SCREEN_COLS];
  logic [4:0] cur_row;
  logic [6:0] cur_col;
  logic [3:0] fg_color;
  logic [3:0] bg_color;

  console_beat_t console_replies [$];
  console_beat_t oldest_reply;
  int errors = 0;
  int sent = 0;
  longint cycles = 0;
  bit steady;

  text_console_writer_core #(
    .COLUMNS(SCREEN_COLS),
    .ROWS(SCREEN_ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .char_code(char_code),
    .cell_row(cell_row),
    .cell_col(cell_col),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .read_char(read_char),
    .read_color(read_color),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [15:0] painted(input logic [7:0] glyph);
    return {bg_color, fg_color, glyph};
  endfunction

  function automatic void line_feed();
    cur_col = '0;
    if (int'(cur_row) + 1 < SCREEN_ROWS) begin
      cur_row = cur_row + 5'd1;
    end else begin
      for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++) begin
        screen[i] = screen[i + SCREEN_COLS];
      end
      for (int c = 0; c < SCREEN_COLS; c++) begin
        screen[(SCREEN_ROWS - 1) * SCREEN_COLS + c] = painted(CH_SPACE);
      end
    end
  endfunction

  function automatic void put_glyph(input logic [7:0] glyph);
    if (int'(cur_col) >= SCREEN_COLS) begin
      line_feed();
    end
    screen[int'(cur_row) * SCREEN_COLS + int'(cur_col)] = painted(glyph);
    cur_col = cur_col + 7'd1;
  endfunction

  function automatic console_beat_t console_apply(input logic [1:0] op,
                                                  input logic [7:0] glyph,
                                                  input logic [4:0] row,
                                                  input logic [6:0] col);
    console_beat_t reply;
    reply = '0;
    case (op)
      OP_PUT: begin
        if (glyph == CH_NEWLINE) begin
          line_feed();
        end else if (glyph == CH_RETURN) begin
          cur_col = '0;
        end else if (glyph == CH_TAB) begin
          repeat (int'(TAB_EXTRA) + 1) put_glyph(CH_SPACE);
        end else begin
          put_glyph(glyph);
        end
      end
      OP_CLEAR: begin
        foreach (screen[i]) screen[i] = painted(CH_SPACE);
        cur_row = '0;
        cur_col = '0;
      end
      OP_READ: begin
        if (int'(row) < SCREEN_ROWS && int'(col) < SCREEN_COLS) begin
          {reply.attr, reply.glyph} = screen[int'(row) * SCREEN_COLS + int'(col)];
        end
      end
      default: begin
      end
    endcase
    reply.row = cur_row;
    reply.col = cur_col;
    return reply;
  endfunction

  task automatic issue(input logic [1:0] op, input logic [7:0] glyph,
                       input logic [4:0] row, input logic [6:0] col,
                       input logic typed, input console_beat_t typed_reply);
    console_beat_t modeled;
    start <= 1'b1;
    opcode <= op;
    char_code <= glyph;
    cell_row <= row;
    cell_col <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    modeled = console_apply(op, glyph, row, col);
    console_replies.push_back(typed ? typed_reply : modeled);
    sent++;
    if (!steady && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (console_replies.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
    cfg_we <= 1'b1;
    cfg_index <= REG_FOREGROUND;
    cfg_data <= fg;
    @(posedge clk);
    fg_color = fg;
    cfg_index <= REG_BACKGROUND;
    cfg_data <= bg;
    @(posedge clk);
    bg_color = bg;
    cfg_we <= 1'b0;
  endtask

  task automatic run_sequence();
    int pick;
    int len;
    logic [1:0] op;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] glyph;
    steady = (sent >= DIRECTED_ROWS + RANDOM_ITEMS - QUIET_TAIL) || ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      issue(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom), PREDICT, NO_REPLY);
    end else if (pick < 26) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 7) == 0) begin
          row = 5'($urandom_range(SCREEN_ROWS, 31));
        end else begin
          row = $urandom_range(0, 1) ? cur_row : 5'($urandom_range(0, SCREEN_ROWS - 1));
        end
        if ($urandom_range(0, 7) == 0) begin
          col = 7'($urandom_range(SCREEN_COLS, 127));
        end else begin
          col = 7'($urandom_range(0, SCREEN_COLS - 1));
        end
        op = ($urandom_range(0, 9) == 0) ? OP_SPARE : OP_READ;
        issue(op, 8'($urandom), row, col, PREDICT, NO_REPLY);
      end
    end else begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 30);
      repeat (len) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          glyph = 8'($urandom_range(32, 126));
        end else if (pick < 8) begin
          glyph = CH_TAB;
        end else begin
          glyph = 8'($urandom);
        end
        issue(OP_PUT, glyph, 5'($urandom), 7'($urandom), PREDICT, NO_REPLY);
      end
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        issue(OP_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom), PREDICT, NO_REPLY);
      end else if (pick < 14) begin
        repeat ($urandom_range(2, 6)) begin
          issue(OP_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom), PREDICT, NO_REPLY);
        end
      end else if (pick < 17) begin
        issue(OP_PUT, CH_RETURN, 5'($urandom), 7'($urandom), PREDICT, NO_REPLY);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (console_replies.size() == 0) begin
        $display("%0t: result beat with none expected, actual %02h %02h %0d %0d",
                 $time, read_char, read_color, cursor_row, cursor_col);
        errors++;
      end else begin
        oldest_reply = console_replies.pop_front();
        if (read_char != oldest_reply.glyph) begin
          $display("%0t: read_char expected %02h actual %02h",
                   $time, oldest_reply.glyph, read_char);
          errors++;
        end
        if (read_color != oldest_reply.attr) begin
          $display("%0t: read_color expected %02h actual %02h",
                   $time, oldest_reply.attr, read_color);
          errors++;
        end
        if (cursor_row != oldest_reply.row) begin
          $display("%0t: cursor_row expected %0d actual %0d",
                   $time, oldest_reply.row, cursor_row);
          errors++;
        end
        if (cursor_col != oldest_reply.col) begin
          $display("%0t: cursor_col expected %0d actual %0d",
                   $time, oldest_reply.col, cursor_col);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("text_console_writer_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_PUT;
    char_code = '0;
    cell_row = '0;
    cell_col = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FOREGROUND;
    cfg_data = '0;
    fg_color = FOREGROUND_RESET;
    bg_color = BACKGROUND_RESET;
    cur_row = '0;
    cur_col = '0;
    foreach (screen[i]) screen[i] = '0;
    steady = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      issue(DIRECTED[i].op, DIRECTED[i].glyph, DIRECTED[i].row, DIRECTED[i].col,
            DIRECTED[i].typed, DIRECTED[i].reply);
    end
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: set_colors(4'd0, 4'd0);
        1: set_colors(4'd15, 4'd15);
        2: set_colors(4'd0, 4'd15);
        default: set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      while (sent < DIRECTED_ROWS + (phase + 1) * RANDOM_ITEMS / PHASES) begin
        run_sequence();
      end
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("text_console_writer_core regression: pass");
    end else begin
      $display("text_console_writer_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_writer_core.sv
src/tcw_checker.sv
tb/tb_text_console_writer_core.sv
